// ===== rtl/xlu_pkg.sv =====
// Package for the XML literal unescaper: payload types, register indexes and fault codes.
package xlu_pkg;

    // Bundle queue between the front and back halves.
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Most results that one input unit can cause.
    localparam int MAX_RESULTS = 3;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_CHAR     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNESCAPE_BRACE = 1'b1;

    // Fault codes carried with each result.
    localparam logic [1:0] FAULT_NONE       = 2'd0;
    localparam logic [1:0] FAULT_BAD_REF    = 2'd1;
    localparam logic [1:0] FAULT_BAD_ENTITY = 2'd2;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_final;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_unit;
        logic        unit_present;
        logic [1:0]  fault;
        logic        run_end;
    } t_result;

    // All results caused by one input unit, slot 0 first.
    typedef struct packed {
        logic [RES_IDX_W-1:0]         count;
        t_result [MAX_RESULTS-1:0]    res;
    } t_bundle;

    // Write side of the bundle queue as seen by the front half.
    typedef struct packed {
        logic    wr;
        t_bundle data;
    } t_queue_wr;

endpackage

// ===== rtl/xml_literal_unescaper.sv =====
// Top level of the XML literal unescaper: front half, bundle queue and back half.
//
// Use: UTF-16 code units of one literal enter on the input queue port (push, full,
// i_item); a transfer happens on a rising edge with push high and full low. Unescaped
// units leave on the result port (empty, pop, o_result); a transfer happens on a
// rising edge with pop high and empty low, always the oldest result first.
// The configuration channel (valid, ready, i_cfg_index, i_cfg_data) is always ready;
// index 0 sets the enclosing quote unit, index 1 the brace/whitespace option. Write it
// only between literals, when no result is outstanding.
// A unit's first result goes through the bundle queue and the output register to the
// result port. Throughput: one unit per cycle while each unit causes at most one result
// and the receiver takes every result. The back half moves one result per cycle while
// the receiver takes them; units with two or three results (surrogate pairs, released
// brackets) hold it longer, and the four-bundle queue absorbs bursts before full rises.
// A unit that causes nothing never enters the queue. The final unit of a literal
// always leaves at least one result, the last one marked with run_end.
// If the receiver stalls, the output register holds its result, the queue fills and
// full rises; nothing is dropped. Reset (synchronous, active low) empties the queue,
// returns the decoder to plain text and clears both configuration registers.
module xml_literal_unescaper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  xlu_pkg::t_in_item               i_item,
    output logic                            empty,
    input  logic                            pop,
    output xlu_pkg::t_result                o_result,
    input  logic                            valid,
    output logic                            ready,
    input  logic [xlu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);

    logic [15:0]        r_quote_char;
    logic               r_unescape_brace;
    logic               accept;
    xlu_pkg::t_queue_wr queue_wr;
    logic               head_valid;
    xlu_pkg::t_bundle   head;
    logic               head_rd;

    // Configuration writes complete at once.
    assign ready  = 1'b1;
    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote_char     <= '0;
            r_unescape_brace <= 1'b0;
        end else if (valid && ready) begin
            unique case (i_cfg_index)
                xlu_pkg::CFG_QUOTE_CHAR:     r_quote_char     <= i_cfg_data;
                xlu_pkg::CFG_UNESCAPE_BRACE: r_unescape_brace <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Front half: decodes each accepted unit into a bundle of results.
    xlu_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_item           (i_item),
        .i_quote_char     (r_quote_char),
        .i_unescape_brace (r_unescape_brace),
        .o_queue_wr       (queue_wr)
    );

    // Queue full also stalls the input, so a bundle always finds room.
    xlu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_queue_wr (queue_wr),
        .o_full     (full),
        .o_valid    (head_valid),
        .o_head     (head),
        .i_rd       (head_rd)
    );

    // Back half: one result per transfer into the output register.
    xlu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_head   (head),
        .o_rd     (head_rd),
        .o_empty  (empty),
        .o_result (o_result),
        .i_pop    (pop)
    );

endmodule

// ===== rtl/xlu_front.sv =====
// Front half: accepts code units, runs the unescape state machine and forms result bundles.
module xlu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  xlu_pkg::t_in_item i_item,
    input  logic [15:0]      i_quote_char,
    input  logic             i_unescape_brace,
    output xlu_pkg::t_queue_wr o_queue_wr
);

    localparam logic [2:0] M_PLAIN      = 3'd0;
    localparam logic [2:0] M_AMP        = 3'd1;
    localparam logic [2:0] M_AMP_A      = 3'd2;
    localparam logic [2:0] M_SKIP       = 3'd3;
    localparam logic [2:0] M_REF_START  = 3'd4;
    localparam logic [2:0] M_REF_DIGITS = 3'd5;
    localparam logic [2:0] M_CDATA_SKIP = 3'd6;
    localparam logic [2:0] M_CDATA      = 3'd7;

    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_LF     = 16'h000A;
    localparam logic [15:0] CH_CR     = 16'h000D;
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_DQUOTE = 16'h0022;
    localparam logic [15:0] CH_HASH   = 16'h0023;
    localparam logic [15:0] CH_AMP    = 16'h0026;
    localparam logic [15:0] CH_APOS   = 16'h0027;
    localparam logic [15:0] CH_DIGIT0 = 16'h0030;
    localparam logic [15:0] CH_SEMI   = 16'h003B;
    localparam logic [15:0] CH_LT     = 16'h003C;
    localparam logic [15:0] CH_GT     = 16'h003E;
    localparam logic [15:0] CH_UPPERA = 16'h0041;
    localparam logic [15:0] CH_RBRACK = 16'h005D;
    localparam logic [15:0] CH_LOWERA = 16'h0061;
    localparam logic [15:0] CH_LOWERG = 16'h0067;
    localparam logic [15:0] CH_LOWERL = 16'h006C;
    localparam logic [15:0] CH_LOWERM = 16'h006D;
    localparam logic [15:0] CH_LOWERQ = 16'h0071;
    localparam logic [15:0] CH_LOWERX = 16'h0078;
    localparam logic [15:0] CH_LBRACE = 16'h007B;
    localparam logic [15:0] CH_RBRACE = 16'h007D;

    localparam logic [20:0] REF_MAX      = 21'h10FFFF;
    localparam logic [20:0] REF_FORCE    = 21'h110000;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [15:0] LAST_BMP_OK  = 16'hFFFD;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [3:0]  CDATA_HDR    = 4'd8;

    logic [2:0]  r_mode, n_mode;
    logic [3:0]  r_skip_cnt, n_skip_cnt;
    logic [1:0]  r_held, n_held;
    logic [20:0] r_ref_value, n_ref_value;
    logic        r_ref_ovf, n_ref_ovf;
    logic        r_hex, n_hex;
    logic        r_drop_valid, n_drop_valid;
    logic [15:0] r_drop_unit, n_drop_unit;

    logic [15:0] c;
    logic [20:0] digit;
    logic [25:0] scaled;
    logic [25:0] next_value;
    logic        next_ovf;
    logic [19:0] supp_off;
    logic        bmp_xml_char;

    logic [1:0]                        v_n;
    xlu_pkg::t_result [xlu_pkg::MAX_RESULTS-1:0] v_res;

    function automatic xlu_pkg::t_result mk(input logic [15:0] unit, input logic present,
                                            input logic [1:0] fault);
        xlu_pkg::t_result r;
        r.out_unit     = unit;
        r.unit_present = present;
        r.fault        = fault;
        r.run_end      = 1'b0;
        return r;
    endfunction

    assign c = i_item.code_unit;

    // Digit value and radix multiply-add for character references.
    always_comb begin
        if (c >= CH_LOWERA) begin
            digit = 21'(c) - 21'd87;
        end else if (c >= CH_UPPERA) begin
            digit = 21'(c) - 21'd55;
        end else if (c >= CH_DIGIT0) begin
            digit = 21'(c) - 21'd48;
        end else begin
            digit = REF_FORCE;
        end
        scaled = r_hex ? (26'(r_ref_value) << 4)
                       : ((26'(r_ref_value) << 3) + (26'(r_ref_value) << 1));
        next_value = scaled + 26'(digit);
        next_ovf   = r_ref_ovf || (next_value > 26'(REF_MAX));
    end

    assign supp_off     = 20'(r_ref_value - SUPP_BASE);
    assign bmp_xml_char = (r_ref_value[15:0] == CH_TAB) || (r_ref_value[15:0] == CH_LF) ||
                          (r_ref_value[15:0] == CH_CR) ||
                          ((r_ref_value[15:0] >= CH_SPACE) && (r_ref_value[15:0] <= 16'hD7FF)) ||
                          (r_ref_value[15:0] >= 16'hE000);

    always_comb begin
        n_mode       = r_mode;
        n_skip_cnt   = r_skip_cnt;
        n_held       = r_held;
        n_ref_value  = r_ref_value;
        n_ref_ovf    = r_ref_ovf;
        n_hex        = r_hex;
        n_drop_valid = 1'b0;
        n_drop_unit  = r_drop_unit;
        v_n          = '0;
        v_res        = '0;

        if (r_drop_valid && (r_drop_unit == c)) begin
            // Second unit of a collapsed pair is swallowed.
        end else begin
            unique case (r_mode)
                M_PLAIN: begin
                    if (c == CH_AMP) begin
                        n_mode = M_AMP;
                    end else if ((c == CH_TAB) || (c == CH_LF) || (c == CH_CR)) begin
                        v_res[v_n] = mk(((i_quote_char != '0) && i_unescape_brace) ? CH_SPACE : c,
                                        1'b1, xlu_pkg::FAULT_NONE);
                        v_n = v_n + 2'd1;
                    end else if ((c == CH_LT) && (i_quote_char == '0)) begin
                        n_skip_cnt = CDATA_HDR;
                        n_mode     = M_CDATA_SKIP;
                    end else begin
                        v_res[v_n] = mk(c, 1'b1, xlu_pkg::FAULT_NONE);
                        v_n = v_n + 2'd1;
                        if (((c == CH_APOS) || (c == CH_DQUOTE)) && (c == i_quote_char)) begin
                            n_drop_valid = 1'b1;
                            n_drop_unit  = c;
                        end
                        if (((c == CH_LBRACE) || (c == CH_RBRACE)) && i_unescape_brace) begin
                            n_drop_valid = 1'b1;
                            n_drop_unit  = c;
                        end
                    end
                end
                M_AMP: begin
                    if (c == CH_LOWERA) begin
                        n_mode = M_AMP_A;
                    end else if ((c == CH_LOWERG) || (c == CH_LOWERL)) begin
                        v_res[v_n] = mk((c == CH_LOWERG) ? CH_GT : CH_LT, 1'b1,
                                        xlu_pkg::FAULT_NONE);
                        v_n = v_n + 2'd1;
                        n_skip_cnt = 4'd2;
                        n_mode     = M_SKIP;
                    end else if (c == CH_LOWERQ) begin
                        v_res[v_n] = mk(CH_DQUOTE, 1'b1, xlu_pkg::FAULT_NONE);
                        v_n = v_n + 2'd1;
                        n_skip_cnt = 4'd4;
                        n_mode     = M_SKIP;
                    end else if (c == CH_HASH) begin
                        n_ref_value = '0;
                        n_ref_ovf   = 1'b0;
                        n_hex       = 1'b0;
                        n_mode      = M_REF_START;
                    end else begin
                        v_res[v_n] = mk('0, 1'b0, xlu_pkg::FAULT_BAD_ENTITY);
                        v_n = v_n + 2'd1;
                        n_mode = M_PLAIN;
                    end
                end
                M_AMP_A: begin
                    if (c == CH_LOWERM) begin
                        v_res[v_n] = mk(CH_AMP, 1'b1, xlu_pkg::FAULT_NONE);
                        n_skip_cnt = 4'd2;
                    end else begin
                        v_res[v_n] = mk(CH_APOS, 1'b1, xlu_pkg::FAULT_NONE);
                        n_skip_cnt = 4'd3;
                    end
                    v_n = v_n + 2'd1;
                    n_mode = M_SKIP;
                end
                M_SKIP, M_CDATA_SKIP: begin
                    if (r_skip_cnt != '0) begin
                        n_skip_cnt = r_skip_cnt - 4'd1;
                    end
                    if (n_skip_cnt == '0) begin
                        if (r_mode == M_CDATA_SKIP) begin
                            n_held = '0;
                            n_mode = M_CDATA;
                        end else begin
                            n_mode = M_PLAIN;
                        end
                    end
                end
                M_REF_START, M_REF_DIGITS: begin
                    if ((r_mode == M_REF_START) && (c == CH_LOWERX)) begin
                        n_hex  = 1'b1;
                        n_mode = M_REF_DIGITS;
                    end else if (c == CH_SEMI) begin
                        n_mode = M_PLAIN;
                        if (r_ref_ovf) begin
                            v_res[v_n] = mk('0, 1'b0, xlu_pkg::FAULT_BAD_REF);
                            v_n = v_n + 2'd1;
                        end else if (r_ref_value <= 21'(LAST_BMP_OK)) begin
                            v_res[v_n] = mk(r_ref_value[15:0], 1'b1,
                                            bmp_xml_char ? xlu_pkg::FAULT_NONE
                                                         : xlu_pkg::FAULT_BAD_REF);
                            v_n = v_n + 2'd1;
                        end else if (r_ref_value >= SUPP_BASE) begin
                            v_res[v_n] = mk(16'(supp_off[19:10]) + HI_SURR_BASE, 1'b1,
                                            xlu_pkg::FAULT_NONE);
                            v_n = v_n + 2'd1;
                            v_res[v_n] = mk(16'(supp_off[9:0]) + LO_SURR_BASE, 1'b1,
                                            xlu_pkg::FAULT_NONE);
                            v_n = v_n + 2'd1;
                        end else begin
                            v_res[v_n] = mk('0, 1'b0, xlu_pkg::FAULT_BAD_REF);
                            v_n = v_n + 2'd1;
                        end
                    end else begin
                        n_ref_ovf   = next_ovf;
                        n_ref_value = next_ovf ? REF_MAX : next_value[20:0];
                        n_mode      = M_REF_DIGITS;
                    end
                end
                M_CDATA: begin
                    if (c == CH_RBRACK) begin
                        if (r_held < 2'd2) begin
                            n_held = r_held + 2'd1;
                        end else begin
                            v_res[v_n] = mk(CH_RBRACK, 1'b1, xlu_pkg::FAULT_NONE);
                            v_n = v_n + 2'd1;
                        end
                    end else if ((c == CH_GT) && (r_held >= 2'd2)) begin
                        n_held = '0;
                        n_mode = M_PLAIN;
                    end else begin
                        for (int k = 0; k < 2; k++) begin
                            if (n_held != '0) begin
                                v_res[v_n] = mk(CH_RBRACK, 1'b1, xlu_pkg::FAULT_NONE);
                                v_n = v_n + 2'd1;
                                n_held = n_held - 2'd1;
                            end
                        end
                        v_res[v_n] = mk(c, 1'b1, xlu_pkg::FAULT_NONE);
                        v_n = v_n + 2'd1;
                    end
                end
                default: begin
                    n_mode = M_PLAIN;
                end
            endcase
        end

        if (i_item.is_final) begin
            // Flush held brackets as room allows, then close the run.
            for (int k = 0; k < 2; k++) begin
                if ((n_held != '0) && (v_n != 2'd3)) begin
                    v_res[v_n] = mk(CH_RBRACK, 1'b1, xlu_pkg::FAULT_NONE);
                    v_n = v_n + 2'd1;
                    n_held = n_held - 2'd1;
                end
            end
            if (v_n == '0) begin
                v_res[v_n] = mk('0, 1'b0, xlu_pkg::FAULT_NONE);
                v_n = v_n + 2'd1;
            end
            v_res[v_n - 2'd1].run_end = 1'b1;
            n_mode       = M_PLAIN;
            n_skip_cnt   = '0;
            n_held       = '0;
            n_ref_value  = '0;
            n_ref_ovf    = 1'b0;
            n_hex        = 1'b0;
            n_drop_valid = 1'b0;
        end
    end

    assign o_queue_wr.wr         = i_accept && (v_n != '0);
    assign o_queue_wr.data.count = v_n;
    assign o_queue_wr.data.res   = v_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_PLAIN;
            r_skip_cnt   <= '0;
            r_held       <= '0;
            r_ref_value  <= '0;
            r_ref_ovf    <= 1'b0;
            r_hex        <= 1'b0;
            r_drop_valid <= 1'b0;
            r_drop_unit  <= '0;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_skip_cnt   <= n_skip_cnt;
            r_held       <= n_held;
            r_ref_value  <= n_ref_value;
            r_ref_ovf    <= n_ref_ovf;
            r_hex        <= n_hex;
            r_drop_valid <= n_drop_valid;
            r_drop_unit  <= n_drop_unit;
        end
    end

    // Brackets are only ever held inside a CDATA section.
    a_held_only_in_cdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != M_CDATA) |-> (r_held == '0))
        else $error("held brackets outside CDATA section");

endmodule

// ===== rtl/xlu_queue.sv =====
// Short queue of result bundles between the front and back halves.
module xlu_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  xlu_pkg::t_queue_wr i_queue_wr,
    output logic               o_full,
    output logic               o_valid,
    output xlu_pkg::t_bundle   o_head,
    input  logic               i_rd
);

    xlu_pkg::t_bundle r_mem [xlu_pkg::QUEUE_DEPTH];

    logic [xlu_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [xlu_pkg::QUEUE_AW:0]   r_count;
    logic                         do_wr, do_rd;

    assign o_full  = (r_count == (xlu_pkg::QUEUE_AW + 1)'(xlu_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_wr   = i_queue_wr.wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_queue_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (xlu_pkg::QUEUE_AW + 1)'(do_wr)
                               - (xlu_pkg::QUEUE_AW + 1)'(do_rd);
        end
    end

    // The front half never offers a bundle while the queue is full.
    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_queue_wr.wr && o_full))
        else $error("bundle offered to a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (xlu_pkg::QUEUE_AW + 1)'(xlu_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== rtl/xlu_back.sv =====
// Back half: walks each bundle one result at a time into the output register.
module xlu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  xlu_pkg::t_bundle i_head,
    output logic             o_rd,
    output logic             o_empty,
    output xlu_pkg::t_result o_result,
    input  logic             i_pop
);

    logic [xlu_pkg::RES_IDX_W-1:0] r_sub;
    logic                          r_out_valid;
    xlu_pkg::t_result              r_out;
    logic                          load;
    logic                          last_in_bundle;

    assign load           = i_valid && (!r_out_valid || i_pop);
    assign last_in_bundle = (r_sub == (i_head.count - 1'b1));
    assign o_rd           = load && last_in_bundle;
    assign o_empty        = !r_out_valid;
    assign o_result       = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= i_head.res[r_sub];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_sub       <= last_in_bundle ? '0 : r_sub + 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Partway through a bundle, that bundle must still sit at the queue head.
    a_sub_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != '0) |-> (i_valid && (r_sub < i_head.count)))
        else $error("result index without a matching bundle");

endmodule

// ===== test/xlu_unescape_check.sv =====
// Checker for the XML literal unescaper: watches all channels, predicts results and compares.
`timescale 1ns / 1ps

module xlu_unescape_check
    import xlu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  t_in_item             i_item,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  t_result              i_result,
    input  logic                 i_valid,
    input  logic                 i_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output int unsigned          o_pending,
    output int unsigned          o_fail_count
);

    localparam logic [15:0] CH_TAB      = 16'h0009;
    localparam logic [15:0] CH_LF       = 16'h000A;
    localparam logic [15:0] CH_CR       = 16'h000D;
    localparam logic [15:0] CH_SPACE    = 16'h0020;
    localparam logic [15:0] CH_QUOT     = 16'h0022;
    localparam logic [15:0] CH_HASH     = 16'h0023;
    localparam logic [15:0] CH_AMP      = 16'h0026;
    localparam logic [15:0] CH_APOS     = 16'h0027;
    localparam logic [15:0] CH_ZERO     = 16'h0030;
    localparam logic [15:0] CH_SEMI     = 16'h003B;
    localparam logic [15:0] CH_LT       = 16'h003C;
    localparam logic [15:0] CH_GT       = 16'h003E;
    localparam logic [15:0] CH_UPPER_A  = 16'h0041;
    localparam logic [15:0] CH_RBRACKET = 16'h005D;
    localparam logic [15:0] CH_LOWER_A  = 16'h0061;
    localparam logic [15:0] CH_G        = 16'h0067;
    localparam logic [15:0] CH_L        = 16'h006C;
    localparam logic [15:0] CH_M        = 16'h006D;
    localparam logic [15:0] CH_Q        = 16'h0071;
    localparam logic [15:0] CH_X        = 16'h0078;
    localparam logic [15:0] CH_LBRACE   = 16'h007B;
    localparam logic [15:0] CH_RBRACE   = 16'h007D;

    localparam logic [20:0] REF_LIMIT   = 21'h10FFFF;
    localparam logic [20:0] PLANE_ONE   = 21'h010000;
    localparam logic [20:0] LAST_BMP_OK = 21'h00FFFD;
    localparam logic [15:0] SURR_HIGH   = 16'hD800;
    localparam logic [15:0] SURR_LOW    = 16'hDC00;

    // Units skipped after the deciding letter of each named entity.
    localparam logic [3:0] SKIP_AMP      = 4'd2;
    localparam logic [3:0] SKIP_APOS     = 4'd3;
    localparam logic [3:0] SKIP_GT_LT    = 4'd2;
    localparam logic [3:0] SKIP_QUOT     = 4'd4;
    localparam logic [3:0] CDATA_HDR_LEN = 4'd8;

    typedef enum logic [2:0] {
        ST_PLAIN,
        ST_AMP,
        ST_AMP_A,
        ST_SKIP,
        ST_REF_START,
        ST_REF_DIGITS,
        ST_CDATA_HDR,
        ST_CDATA
    } t_scan_state;

    logic [15:0] cfg_quote;
    logic        cfg_brace;

    t_scan_state scan_state;
    logic [3:0]  skip_left;
    logic [1:0]  held_rb;
    logic [20:0] ref_acc;
    logic        ref_sat;
    logic        ref_hex;
    logic        repeat_armed;
    logic [15:0] repeat_unit;

    t_result     burst[$];
    t_result     want_results[$];

    task automatic clear_scan();
        scan_state   = ST_PLAIN;
        skip_left    = '0;
        held_rb      = '0;
        ref_acc      = '0;
        ref_sat      = 1'b0;
        ref_hex      = 1'b0;
        repeat_armed = 1'b0;
        repeat_unit  = '0;
    endtask

    task automatic put(input logic [15:0] unit, input logic present, input logic [1:0] fault);
        t_result r;
        r.out_unit     = unit;
        r.unit_present = present;
        r.fault        = fault;
        r.run_end      = 1'b0;
        burst.push_back(r);
    endtask

    function automatic logic xml_char_ok(input logic [20:0] v);
        return v == {5'd0, CH_TAB} || v == {5'd0, CH_LF} || v == {5'd0, CH_CR} ||
               (v >= {5'd0, CH_SPACE} && v < {5'd0, SURR_HIGH}) ||
               (v >= 21'h00E000 && v <= LAST_BMP_OK) ||
               (v >= PLANE_ONE && v <= REF_LIMIT);
    endfunction

    // Radix multiply-add; anything below '0' or past the limit saturates.
    task automatic take_digit(input logic [15:0] c);
        logic [63:0] d;
        logic [63:0] nv;
        if (c >= CH_LOWER_A) begin
            d = 64'(c) - 64'(CH_LOWER_A) + 64'd10;
        end else if (c >= CH_UPPER_A) begin
            d = 64'(c) - 64'(CH_UPPER_A) + 64'd10;
        end else if (c >= CH_ZERO) begin
            d = 64'(c) - 64'(CH_ZERO);
        end else begin
            d = 64'(REF_LIMIT) + 64'd1;
        end
        nv = 64'(ref_acc) * (ref_hex ? 64'd16 : 64'd10) + d;
        if (ref_sat || nv > 64'(REF_LIMIT)) begin
            ref_sat = 1'b1;
            ref_acc = REF_LIMIT;
        end else begin
            ref_acc = nv[20:0];
        end
    endtask

    task automatic finish_ref();
        logic [20:0] w;
        if (ref_sat) begin
            put('0, 1'b0, FAULT_BAD_REF);
        end else if (ref_acc <= LAST_BMP_OK) begin
            put(ref_acc[15:0], 1'b1, xml_char_ok(ref_acc) ? FAULT_NONE : FAULT_BAD_REF);
        end else if (ref_acc >= PLANE_ONE) begin
            w = ref_acc - PLANE_ONE;
            put(SURR_HIGH + {6'd0, w[19:10]}, 1'b1, FAULT_NONE);
            put(SURR_LOW + {6'd0, w[9:0]}, 1'b1, FAULT_NONE);
        end else begin
            put('0, 1'b0, FAULT_BAD_REF);
        end
    endtask

    task automatic decode_unit(input t_in_item it);
        logic [15:0] c;
        logic        hit_repeat;
        c = it.code_unit;
        burst.delete();
        hit_repeat   = repeat_armed && repeat_unit == c;
        repeat_armed = 1'b0;
        if (!hit_repeat) begin
            case (scan_state)
                ST_PLAIN: begin
                    if (c == CH_AMP) begin
                        scan_state = ST_AMP;
                    end else if (c == CH_TAB || c == CH_LF || c == CH_CR) begin
                        put((cfg_quote != 0 && cfg_brace) ? CH_SPACE : c, 1'b1, FAULT_NONE);
                    end else if (c == CH_LT && cfg_quote == 0) begin
                        skip_left  = CDATA_HDR_LEN;
                        scan_state = ST_CDATA_HDR;
                    end else begin
                        put(c, 1'b1, FAULT_NONE);
                        if (c == CH_APOS || c == CH_QUOT) begin
                            if (c == cfg_quote) begin
                                repeat_armed = 1'b1;
                                repeat_unit  = c;
                            end
                        end else if ((c == CH_LBRACE || c == CH_RBRACE) && cfg_brace) begin
                            repeat_armed = 1'b1;
                            repeat_unit  = c;
                        end
                    end
                end
                ST_AMP: begin
                    if (c == CH_LOWER_A) begin
                        scan_state = ST_AMP_A;
                    end else if (c == CH_G || c == CH_L) begin
                        put(c == CH_G ? CH_GT : CH_LT, 1'b1, FAULT_NONE);
                        skip_left  = SKIP_GT_LT;
                        scan_state = ST_SKIP;
                    end else if (c == CH_Q) begin
                        put(CH_QUOT, 1'b1, FAULT_NONE);
                        skip_left  = SKIP_QUOT;
                        scan_state = ST_SKIP;
                    end else if (c == CH_HASH) begin
                        ref_acc    = '0;
                        ref_sat    = 1'b0;
                        ref_hex    = 1'b0;
                        scan_state = ST_REF_START;
                    end else begin
                        put('0, 1'b0, FAULT_BAD_ENTITY);
                        scan_state = ST_PLAIN;
                    end
                end
                ST_AMP_A: begin
                    if (c == CH_M) begin
                        put(CH_AMP, 1'b1, FAULT_NONE);
                        skip_left = SKIP_AMP;
                    end else begin
                        put(CH_APOS, 1'b1, FAULT_NONE);
                        skip_left = SKIP_APOS;
                    end
                    scan_state = ST_SKIP;
                end
                ST_SKIP: begin
                    if (skip_left != 0) skip_left = skip_left - 1'b1;
                    if (skip_left == 0) scan_state = ST_PLAIN;
                end
                ST_REF_START, ST_REF_DIGITS: begin
                    if (c == CH_SEMI) begin
                        finish_ref();
                        scan_state = ST_PLAIN;
                    end else if (c == CH_X && scan_state == ST_REF_START) begin
                        ref_hex    = 1'b1;
                        scan_state = ST_REF_DIGITS;
                    end else begin
                        take_digit(c);
                        scan_state = ST_REF_DIGITS;
                    end
                end
                ST_CDATA_HDR: begin
                    if (skip_left != 0) skip_left = skip_left - 1'b1;
                    if (skip_left == 0) begin
                        held_rb    = '0;
                        scan_state = ST_CDATA;
                    end
                end
                default: begin
                    // Up to two ']' wait to see whether a '>' closes the section.
                    if (c == CH_RBRACKET) begin
                        if (held_rb < 2) held_rb = held_rb + 1'b1;
                        else put(CH_RBRACKET, 1'b1, FAULT_NONE);
                    end else if (c == CH_GT && held_rb >= 2) begin
                        held_rb    = '0;
                        scan_state = ST_PLAIN;
                    end else begin
                        while (held_rb != 0) begin
                            put(CH_RBRACKET, 1'b1, FAULT_NONE);
                            held_rb = held_rb - 1'b1;
                        end
                        put(c, 1'b1, FAULT_NONE);
                    end
                end
            endcase
        end
        if (it.is_final) begin
            while (held_rb != 0 && burst.size() < MAX_RESULTS) begin
                put(CH_RBRACKET, 1'b1, FAULT_NONE);
                held_rb = held_rb - 1'b1;
            end
            if (burst.size() == 0) put('0, 1'b0, FAULT_NONE);
            burst[burst.size()-1].run_end = 1'b1;
            clear_scan();
        end
        foreach (burst[i]) want_results.push_back(burst[i]);
    endtask

    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            cfg_quote = '0;
            cfg_brace = 1'b0;
            clear_scan();
            want_results.delete();
        end else begin
            if (i_valid && i_ready) begin
                if (i_cfg_index == CFG_QUOTE_CHAR) cfg_quote = i_cfg_data;
                else if (i_cfg_index == CFG_UNESCAPE_BRACE) cfg_brace = i_cfg_data[0];
            end
            if (i_push && !i_full) decode_unit(i_item);
            if (i_pop && !i_empty) begin
                if (want_results.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    $display("%0t: unexpected result %h, nothing expected", $time,
                             i_result);
                end else begin
                    exp_res = want_results.pop_front();
                    if (i_result.out_unit !== exp_res.out_unit ||
                        i_result.unit_present !== exp_res.unit_present ||
                        i_result.fault !== exp_res.fault ||
                        i_result.run_end !== exp_res.run_end) begin
                        o_fail_count = o_fail_count + 1;
                        $display({"%0t: result mismatch, expected unit %h present %b ",
                                  "fault %0d end %b, actual unit %h present %b ",
                                  "fault %0d end %b"}, $time,
                                 exp_res.out_unit, exp_res.unit_present, exp_res.fault,
                                 exp_res.run_end, i_result.out_unit,
                                 i_result.unit_present, i_result.fault,
                                 i_result.run_end);
                    end
                end
            end
        end
        o_pending = want_results.size();
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the XML literal unescaper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import xlu_pkg::*;

    // The run is short; this bound only catches a hang, many times the slowest
    // correct run (every unit bursting three results into a mostly stalled receiver).
    localparam int CYCLE_LIMIT = 200000;
    localparam int CHUNK_UNITS = 52;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    t_in_item             i_item = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    t_result              o_result;
    logic                 valid = 1'b0;
    logic                 ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data = '0;

    int unsigned pending;
    int unsigned fail_count;
    int unsigned cycle_count = 0;
    int unsigned units_sent = 0;
    int          send_idle_pct = 36;
    int          recv_idle_pct = 70;
    logic [15:0] cur_quote = '0;

    // Code units of the literal being built, sent in order with the last one final.
    logic [15:0] lit_units[$];

    int unsigned corner_vals[16] = '{
        32'h0, 32'h9, 32'hA, 32'hD, 32'h1F, 32'h20, 32'hD7FF, 32'hD800,
        32'hDFFF, 32'hE000, 32'hFFFD, 32'hFFFE, 32'hFFFF, 32'h10000, 32'h10FFFF,
        32'h110000
    };
    string cdata_bits[6] = '{"]", "]]", "]]]", "a", ">", "]>"};
    string junk_chars = "!/-gZ";

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // The receiver decides afresh at every falling edge whether it takes a result.
    always @(negedge i_clk) pop <= ($urandom_range(99) >= recv_idle_pct);

    xml_literal_unescaper DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .valid       (valid),
        .ready       (ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    xlu_unescape_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .i_valid      (valid),
        .i_ready      (ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Every task below starts and ends at a falling edge, so push and valid are
    // assigned at most once per time step even when one transfer follows another.
    task automatic send_unit(input logic [15:0] cu, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= '{code_unit: cu, is_final: fin};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        units_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_literal();
        foreach (lit_units[i]) send_unit(lit_units[i], i == lit_units.size() - 1);
        lit_units.delete();
    endtask

    // The sender holds off until every expected result has been taken. A unit
    // that causes nothing never shows as pending, so a few more cycles let the
    // block settle before the registers may change.
    task automatic drain();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        valid       <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] quote, input logic brace);
        write_reg(CFG_QUOTE_CHAR, quote);
        write_reg(CFG_UNESCAPE_BRACE, {15'd0, brace});
        valid     <= 1'b0;
        cur_quote  = quote;
    endtask

    task automatic add_text(input string s);
        foreach (s[i]) lit_units.push_back({8'h00, s[i]});
    endtask

    // Digits of a character reference. The value leans toward the boundaries of
    // the XML character ranges, the surrogate pair range and saturation. Now and
    // then the digits are empty, padded with a zero or end in a stray character.
    function automatic string ref_digits(input bit hex);
        int unsigned v;
        string       s;
        int          k;
        case ($urandom_range(6))
            0:       v = $urandom_range(127);
            1:       v = $urandom_range(16'hFFFF);
            2:       v = $urandom_range(32'h10000, 32'h10FFFF);
            3:       v = corner_vals[$urandom_range(15)];
            4:       v = $urandom;
            5:       v = $urandom_range(32'h110000, 32'h2000000);
            default: v = $urandom_range(32'h20, 32'h7F);
        endcase
        if (hex) begin
            s = $sformatf("%0h", v);
            if ($urandom_range(1) == 1) s = s.toupper();
        end else begin
            s = $sformatf("%0d", v);
        end
        if ($urandom_range(7) == 0) s = {"0", s};
        if ($urandom_range(11) == 0) begin
            k = $urandom_range(junk_chars.len() - 1);
            s = {s, junk_chars.substr(k, k)};
        end
        if ($urandom_range(11) == 0) s = "";
        return s;
    endfunction

    // One well-formed piece of literal text with random content, or a bit of noise.
    task automatic add_fragment();
        int          pick;
        logic [15:0] q;
        pick = $urandom_range(99);
        if (pick < 25) begin
            repeat ($urandom_range(1, 4)) lit_units.push_back(16'($urandom_range(16'h20, 16'h7E)));
        end else if (pick < 35) begin
            case ($urandom_range(5))
                0: add_text("&amp;");
                1: add_text("&apos;");
                2: add_text("&gt;");
                3: add_text("&lt;");
                4: add_text("&quot;");
                default: begin
                    add_text("&");
                    lit_units.push_back(16'($urandom_range(16'h20, 16'h7E)));
                end
            endcase
        end else if (pick < 50) begin
            add_text({"&#", ref_digits(1'b0), ";"});
        end else if (pick < 63) begin
            add_text({"&#x", ref_digits(1'b1), ";"});
        end else if (pick < 73) begin
            add_text("<![CDATA[");
            repeat ($urandom_range(0, 4)) add_text(cdata_bits[$urandom_range(5)]);
            if ($urandom_range(9) != 0) add_text("]]>");
        end else if (pick < 83) begin
            case ($urandom_range(3))
                0, 1: begin
                    // A doubled or tripled quote; the double quote stands in outside quoted literals.
                    q = (cur_quote != 0) ? cur_quote : 16'h0022;
                    repeat ($urandom_range(2, 3)) lit_units.push_back(q);
                end
                2:       add_text("{{");
                default: add_text("}}x}");
            endcase
        end else if (pick < 91) begin
            // Tab, line feed or carriage return.
            case ($urandom_range(2))
                0:       lit_units.push_back(16'h0009);
                1:       lit_units.push_back(16'h000A);
                default: lit_units.push_back(16'h000D);
            endcase
        end else begin
            repeat ($urandom_range(1, 3)) lit_units.push_back(16'($urandom_range(16'hFFFF)));
        end
    endtask

    // A literal is a few pieces; a few literals are cut short at a random unit so
    // that an entity, reference, skip or CDATA section is left unfinished.
    task automatic make_literal();
        int keep;
        repeat ($urandom_range(1, 5)) add_fragment();
        if ($urandom_range(99) < 8) begin
            keep = $urandom_range(1, lit_units.size());
            while (lit_units.size() > keep) void'(lit_units.pop_back());
        end
    endtask

    // Register settings of the random part, the extremes of both among them.
    task automatic apply_setting(input int idx);
        logic [15:0] q;
        case (idx)
            0: set_config(16'h0000, 1'b1);
            1: set_config(16'h0022, 1'b1);
            2: set_config(16'h0027, 1'b0);
            3: set_config(16'hFFFF, 1'b1);
            4: set_config(16'h007B, 1'b1);
            default: begin
                case ($urandom_range(3))
                    0:       q = 16'h0000;
                    1:       q = 16'h0022;
                    2:       q = 16'h0027;
                    default: q = 16'($urandom_range(16'hFFFF));
                endcase
                set_config(q, 1'($urandom_range(1)));
            end
        endcase
    endtask

    // Hang guard: a cycle counter ends the run if the stimulus or the drain stalls.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int chunk_end;
        // Synchronous reset, held from the start and released at a falling edge.
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, with the registers at their reset values (element content).
        // Extremes of the code unit, ending a literal on an all-ones unit.
        lit_units.push_back(16'h0000);
        lit_units.push_back(16'hFFFF);
        send_literal();
        // Unknown entity letter as the final unit.
        add_text("&z");
        send_literal();
        // Empty character reference gives value zero with a fault.
        add_text("&#;");
        send_literal();
        // A digit below '0' saturates the value, so the semicolon reports a fault.
        add_text("&#!;");
        send_literal();
        // A control character that is not an XML character keeps its unit but faults.
        add_text("&#x1;");
        send_literal();
        // CDATA whose literal ends on held brackets: both come out at the final unit.
        add_text("<![CDATA[]]");
        send_literal();

        // Random part: three idling patterns, each with two register settings. The
        // block must be quiet before every register write.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 70;
                end
                1: begin
                    send_idle_pct = 70;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < 2; k++) begin
                drain();
                apply_setting(ph * 2 + k);
                chunk_end = units_sent + CHUNK_UNITS;
                while (units_sent < chunk_end) begin
                    make_literal();
                    send_literal();
                    // Now and then the sender waits for the result side to run dry.
                    if ($urandom_range(99) < 3) drain();
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/xlu_pkg.sv
rtl/xlu_front.sv
rtl/xlu_queue.sv
rtl/xlu_back.sv
rtl/xml_literal_unescaper.sv
test/xlu_unescape_check.sv
test/tb.sv
